>>> rtl/assert_macros.svh
// concurrent assertion helpers, sampled on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every sampled edge out of reset
`define SDES_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("sdes assertion failed");

// expression must never be true out of reset
`define SDES_NEVER(label, expr) \
	`SDES_ASSERT(label, !(expr))

`else

`define SDES_ASSERT(label, prop)
`define SDES_NEVER(label, expr)

`endif

`endif

>>> rtl/sdes_pkg.sv
`default_nettype none

package sdes_pkg;

	localparam int unsigned KEY_W   = 10;
	localparam int unsigned BLOCK_W = 8;
	localparam int unsigned SUBK_W  = 8;
	localparam int unsigned HALF_W  = 4;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	localparam logic REG_CIPHER_KEY = 1'b0;

	// indexed by {row, col}
	localparam logic [1:0] SBOX0 [16] = '{
		2'd1, 2'd0, 2'd3, 2'd2,
		2'd3, 2'd2, 2'd1, 2'd0,
		2'd0, 2'd2, 2'd1, 2'd3,
		2'd3, 2'd1, 2'd3, 2'd2
	};
	localparam logic [1:0] SBOX1 [16] = '{
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd2, 2'd0, 2'd1, 2'd3,
		2'd3, 2'd0, 2'd1, 2'd0,
		2'd2, 2'd1, 2'd0, 2'd3
	};

	function automatic logic [KEY_W-1:0] p10(input logic [KEY_W-1:0] k);
		return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
	endfunction

	function automatic logic [SUBK_W-1:0] p8(input logic [KEY_W-1:0] x);
		return {x[4], x[7], x[3], x[6], x[2], x[5], x[0], x[1]};
	endfunction

	// rotate both 5-bit halves left by one
	function automatic logic [KEY_W-1:0] ls1(input logic [KEY_W-1:0] x);
		return {x[8:5], x[9], x[3:0], x[4]};
	endfunction

	// rotate both 5-bit halves left by three
	function automatic logic [KEY_W-1:0] ls3(input logic [KEY_W-1:0] x);
		return {x[6:5], x[9:7], x[1:0], x[4:2]};
	endfunction

	function automatic logic [SUBK_W-1:0] subkey1(input logic [KEY_W-1:0] k);
		return p8(ls1(p10(k)));
	endfunction

	function automatic logic [SUBK_W-1:0] subkey2(input logic [KEY_W-1:0] k);
		return p8(ls3(p10(k)));
	endfunction

	function automatic logic [BLOCK_W-1:0] ip(input logic [BLOCK_W-1:0] b);
		return {b[6], b[2], b[5], b[7], b[4], b[0], b[3], b[1]};
	endfunction

	function automatic logic [BLOCK_W-1:0] ip_inv(input logic [BLOCK_W-1:0] b);
		return {b[4], b[7], b[5], b[3], b[1], b[6], b[0], b[2]};
	endfunction

	function automatic logic [SUBK_W-1:0] ep(input logic [HALF_W-1:0] r);
		return {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]};
	endfunction

	function automatic logic [HALF_W-1:0] p4(input logic [HALF_W-1:0] s);
		return {s[2], s[0], s[1], s[3]};
	endfunction

endpackage

`default_nettype wire

>>> rtl/sdes_round.sv
`default_nettype none

// one feistel round: right half passes, left half takes the round function
module sdes_round (
	input  wire logic [sdes_pkg::BLOCK_W-1:0] blk,
	input  wire logic [sdes_pkg::SUBK_W-1:0]  subkey,
	output logic      [sdes_pkg::BLOCK_W-1:0] result
);
	import sdes_pkg::*;

	logic [HALF_W-1:0] left;
	logic [HALF_W-1:0] right;
	logic [SUBK_W-1:0] x;
	logic [1:0]        s0_out;
	logic [1:0]        s1_out;
	logic [HALF_W-1:0] f;

	assign left  = blk[BLOCK_W-1:HALF_W];
	assign right = blk[HALF_W-1:0];
	assign x     = ep(right) ^ subkey;

	// row from the outer bits, column from the inner pair
	assign s0_out = SBOX0[{x[7], x[4], x[6], x[5]}];
	assign s1_out = SBOX1[{x[3], x[0], x[2], x[1]}];
	assign f      = p4({s0_out, s1_out});

	assign result = {left ^ f, right};

endmodule

`default_nettype wire

>>> rtl/sdes_byte_cipher_core.sv
// channel   dir  signals                     contents
// s_axis    in   s_tvalid s_tready s_tdata   tdata[7:0] block_in, tuser[0] op
//                s_tuser
// m_axis    out  m_tvalid m_tready m_tdata   tdata[7:0] block_out
// apb       in   psel penable pwrite paddr   register 0 at 0x0: cipher_key[9:0]
//                pwdata prdata pready
//
// three register stages (ip, first round and swap, second round and ip inverse);
// a byte passes through them in that order from its transaction on s_axis to m_tdata
// one byte per cycle sustained while m_tready stays high;
// the round function between stages sets the clock
// each stage holds its byte while the stage after it is full and stalled
// reset clears the stage valid bits and the key to zero

`default_nettype none

module sdes_byte_cipher_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [sdes_pkg::BLOCK_W-1:0]  s_tdata,  // [7:0] block_in
	input  wire logic                          s_tuser,  // [0] op
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [sdes_pkg::BLOCK_W-1:0]  m_tdata,  // [7:0] block_out
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [2:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);
	import sdes_pkg::*;

	logic [KEY_W-1:0]   key_q;
	logic [SUBK_W-1:0]  k1_q;
	logic [SUBK_W-1:0]  k2_q;
	logic               cfg_wr;

	logic               v_s1, v_s2, v_s3;
	logic               op_s1, op_s2;
	logic [BLOCK_W-1:0] blk_s1, blk_s2, blk_s3;
	logic               en1, en2, en3;

	logic [SUBK_W-1:0]  ka, kb;
	logic [BLOCK_W-1:0] r1_out, r2_out;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CIPHER_KEY);
	assign prdata = (paddr[2] == REG_CIPHER_KEY) ? {22'd0, key_q} : 32'd0;

	// subkeys kept alongside the key so the datapath never sees the schedule
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			k1_q  <= subkey1('0);
			k2_q  <= subkey2('0);
		end else if (cfg_wr) begin
			key_q <= pwdata[KEY_W-1:0];
			k1_q  <= subkey1(pwdata[KEY_W-1:0]);
			k2_q  <= subkey2(pwdata[KEY_W-1:0]);
		end
	end

	assign en3      = !v_s3 || m_tready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;

	assign ka = (op_s1 == OP_DECRYPT) ? k2_q : k1_q;
	assign kb = (op_s2 == OP_DECRYPT) ? k1_q : k2_q;

	sdes_round u_round1 (
		.blk    (blk_s1),
		.subkey (ka),
		.result (r1_out)
	);

	sdes_round u_round2 (
		.blk    (blk_s2),
		.subkey (kb),
		.result (r2_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			blk_s1 <= ip(s_tdata);
			op_s1  <= s_tuser;
		end
		if (en2) begin
			blk_s2 <= {r1_out[HALF_W-1:0], r1_out[BLOCK_W-1:HALF_W]};
			op_s2  <= op_s1;
		end
		if (en3) begin
			blk_s3 <= ip_inv(r2_out);
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = blk_s3;

	`include "assert_macros.svh"

	// an empty output stage always leaves room at the input
	`SDES_ASSERT(a_ready_when_drained, !v_s3 |-> s_tready)
	// a full first stage moves on when the second stage takes
	`SDES_ASSERT(a_s2_load, (v_s1 && en2) |=> v_s2)
	// a stalled middle stage keeps its byte
	`SDES_ASSERT(a_s2_hold, (v_s2 && !en3) |=> (v_s2 && $stable(blk_s2) && $stable(op_s2)))
	// subkeys follow a key write
	`SDES_ASSERT(a_key_sched, cfg_wr |=> (k1_q == subkey1($past(pwdata[KEY_W-1:0]))
		&& k2_q == subkey2($past(pwdata[KEY_W-1:0]))))

endmodule

`default_nettype wire
